@@ rtl/gbrnp_pkg.sv @@
package gbrnp_pkg;

   // Grid geometry and storage sizes.
   localparam int MAX_DIM      = 512;
   localparam int BUCKET_SLOTS = 4;
   localparam int ID_BITS      = 16;
   localparam int CELL         = 3;
   localparam int GRID_N       = MAX_DIM / CELL + 1;
   localparam int NUM_BUCKETS  = GRID_N * GRID_N;
   localparam int BKT_AW       = $clog2(NUM_BUCKETS);

   // Field and datapath widths.
   localparam int PIX_W    = $clog2(MAX_DIM);
   localparam int COORD_W  = PIX_W + 4;
   localparam int DIM_W    = PIX_W + 1;
   localparam int CFG_W    = 10;
   localparam int GRID_W   = $clog2(GRID_N + 1);
   localparam int FILL_W   = $clog2(BUCKET_SLOTS + 1);
   localparam int SLOT_W   = 2 * COORD_W + ID_BITS;
   localparam int ROW_W    = FILL_W + BUCKET_SLOTS * SLOT_W;
   localparam int DIST_W   = 2 * COORD_W + 1;
   localparam int LIMIT_SQ = CELL * CELL * 256;

   // Reciprocal for the division by the bucket size.
   localparam int RECIP_SH = DIM_W + 2;
   localparam int RECIP    = (1 << RECIP_SH) / CELL + 1;
   localparam int PROD_W   = 2 * DIM_W + 2;

   // Request codes.
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_STORED   = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_OUTSIDE  = 3'd2;
   localparam logic [2:0] ST_MATCH    = 3'd3;
   localparam logic [2:0] ST_NO_MATCH = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   // Register indexes.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [ID_BITS-1:0] id;
   } slot_type;

   typedef struct packed {
      logic [FILL_W-1:0]                fill;
      slot_type [BUCKET_SLOTS-1:0]      slot;
   } bucket_type;

   // Divide a pixel count by the bucket size with a reciprocal multiply.
   function automatic logic [GRID_W-1:0] div_cell(input logic [DIM_W-1:0] p);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(p) * PROD_W'(RECIP);
      return GRID_W'(prod >> RECIP_SH);
   endfunction

   // Clamp a dimension register to the legal range.
   function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

@@ rtl/gbrnp_ram.sv @@
module gbrnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port with registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/grid_bucket_radius_nearest_point.sv @@
// Insert: one bucket read and, only when the bucket has a free slot, one write-back.
// Query: n = 1..9 buckets are scanned, one bucket a cycle through the single bucket memory
// port, and their slots pass a two-stage distance pipeline before the result.
// Outside inserts, queries with nothing to scan and unknown codes answer without a memory access.
// Clear and reset: a sweep over all 29241 buckets of the bucket memory, one bucket a cycle;
// busy stays high meanwhile and a clear answers when the sweep ends; results cannot stall.
module grid_bucket_radius_nearest_point (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_type,
   input  logic [gbrnp_pkg::COORD_W-1:0]   req_x_pos,
   input  logic [gbrnp_pkg::COORD_W-1:0]   req_y_pos,
   input  logic [15:0]                     req_point_id,
   output logic                            rsp_valid,
   output logic [2:0]                      rsp_status,
   output logic [15:0]                     rsp_match_id,
   output logic [11:0]                     rsp_match_dist_sq,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [gbrnp_pkg::CFG_W-1:0]     csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_PREP2  = 3'd2;
   localparam logic [2:0] S_INS_RD = 3'd3;
   localparam logic [2:0] S_INS_WR = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_DRAIN  = 3'd6;
   localparam logic [2:0] S_CLR    = 3'd7;

   localparam int NS = gbrnp_pkg::BUCKET_SLOTS;
   localparam int CW = gbrnp_pkg::COORD_W;
   localparam int GW = gbrnp_pkg::GRID_W;
   localparam int AW = gbrnp_pkg::BKT_AW;
   localparam int DW = gbrnp_pkg::DIST_W;

   // Control registers.
   logic [2:0]                      state_ff, state_in;
   logic [gbrnp_pkg::CFG_W-1:0]     width_ff, height_ff;
   logic [AW-1:0]                   clr_addr_ff, clr_addr_in;
   logic                            clr_rsp_ff, clr_rsp_in;
   logic                            s1_vld_ff, s1_vld_in;
   logic                            s2_vld_ff, s2_vld_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [1:0]                      req_ff;
   logic [CW-1:0]                   x_ff, y_ff;
   logic [15:0]                     id_ff;
   logic [GW-1:0]                   row_ff, col_ff, rmax_ff, cmax_ff;
   logic [GW-1:0]                   row_in, col_in, rmax_in, cmax_in;
   logic                            outside_ff, outside_in;
   logic [GW-1:0]                   r_ff, c_ff, r1_ff, c0_ff, c1_ff;
   logic [GW-1:0]                   r_in, c_in, r1_in, c0_in, c1_in;
   logic [AW-1:0]                   base_ff, base_in;
   logic [DW-1:0]                   dsq_ff [NS];
   logic [DW-1:0]                   dsq_in [NS];
   logic [NS-1:0]                   ok_ff, ok_in;
   logic [gbrnp_pkg::ID_BITS-1:0]   sid_ff [NS];
   logic [gbrnp_pkg::ID_BITS-1:0]   sid_in [NS];
   logic [DW-1:0]                   best_ff, best_in;
   logic [gbrnp_pkg::ID_BITS-1:0]   best_id_ff, best_id_in;
   logic                            found_ff, found_in;
   logic [2:0]                      rsp_status_ff, rsp_status_in;
   logic [15:0]                     rsp_id_ff, rsp_id_in;
   logic [11:0]                     rsp_dist_ff, rsp_dist_in;

   // Memory port and combinational helpers.
   logic                            ram_we;
   logic [AW-1:0]                   ram_addr;
   logic [gbrnp_pkg::ROW_W-1:0]     ram_wdata, ram_rdata;
   gbrnp_pkg::bucket_type           rd_bkt, wr_bkt;
   logic [gbrnp_pkg::DIM_W-1:0]     w_eff, h_eff;
   logic [GW:0]                     r0_w, r1_w, c0_w, c1_w;
   logic                            scan_empty;
   logic [GW-1:0]                   mrow;
   logic [gbrnp_pkg::FILL_W-1:0]    nfill;
   logic signed [CW:0]              dx, dy;
   logic signed [2*CW+1:0]          sqx, sqy;
   logic [CW:0]                     qx16, qy16;

   assign w_eff = gbrnp_pkg::dim_of(width_ff);
   assign h_eff = gbrnp_pkg::dim_of(height_ff);
   assign rd_bkt = gbrnp_pkg::bucket_type'(ram_rdata);
   assign qx16 = {1'b0, x_ff[CW-1:4], 4'b0000};
   assign qy16 = {1'b0, y_ff[CW-1:4], 4'b0000};

   gbrnp_ram #(
      .WIDTH(gbrnp_pkg::ROW_W),
      .DEPTH(gbrnp_pkg::NUM_BUCKETS)
   ) u_bucket_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Neighborhood bounds, clamped to the current grid.
   always_comb begin
      r0_w = (row_ff == '0) ? '0 : ((GW+1)'(row_ff) - (GW+1)'(1));
      r1_w = ((GW+1)'(row_ff) + (GW+1)'(1) > (GW+1)'(rmax_ff)) ?
             (GW+1)'(rmax_ff) : ((GW+1)'(row_ff) + (GW+1)'(1));
      c0_w = (col_ff == '0) ? '0 : ((GW+1)'(col_ff) - (GW+1)'(1));
      c1_w = ((GW+1)'(col_ff) + (GW+1)'(1) > (GW+1)'(cmax_ff)) ?
             (GW+1)'(cmax_ff) : ((GW+1)'(col_ff) + (GW+1)'(1));
      scan_empty = (r0_w > r1_w) || (c0_w > c1_w);
      mrow = (req_ff == gbrnp_pkg::REQ_INSERT) ? row_ff : GW'(r0_w);
   end

   // Squared distances of the four slots of the bucket just read.
   always_comb begin
      nfill = (32'(rd_bkt.fill) > NS) ? gbrnp_pkg::FILL_W'(NS) : rd_bkt.fill;
      dx = '0;
      dy = '0;
      sqx = '0;
      sqy = '0;
      for (int k = 0; k < NS; k++) begin
         dx = signed'({1'b0, rd_bkt.slot[k].x}) - signed'(qx16);
         dy = signed'({1'b0, rd_bkt.slot[k].y}) - signed'(qy16);
         sqx = (2*CW+2)'(dx) * (2*CW+2)'(dx);
         sqy = (2*CW+2)'(dy) * (2*CW+2)'(dy);
         dsq_in[k] = DW'(unsigned'(sqx)) + DW'(unsigned'(sqy));
         ok_in[k] = (gbrnp_pkg::FILL_W'(k) < nfill);
         sid_in[k] = rd_bkt.slot[k].id;
      end
   end

   // Keep the nearest slot; a later one wins only when strictly closer.
   always_comb begin
      best_in = best_ff;
      best_id_in = best_id_ff;
      found_in = found_ff;
      if (s2_vld_ff) begin
         for (int k = 0; k < NS; k++) begin
            if (ok_ff[k] && (dsq_ff[k] < best_in)) begin
               best_in = dsq_ff[k];
               best_id_in = sid_ff[k];
               found_in = 1'b1;
            end
         end
      end
      if (state_ff == S_PREP2) begin
         best_in = DW'(gbrnp_pkg::LIMIT_SQ);
         best_id_in = '0;
         found_in = 1'b0;
      end
   end

   // Insert write-back: the new keypoint goes into the next free slot.
   always_comb begin
      wr_bkt = rd_bkt;
      for (int k = 0; k < NS; k++) begin
         if (gbrnp_pkg::FILL_W'(k) == rd_bkt.fill) begin
            wr_bkt.slot[k].x = x_ff;
            wr_bkt.slot[k].y = y_ff;
            wr_bkt.slot[k].id = gbrnp_pkg::ID_BITS'(id_ff);
         end
      end
      wr_bkt.fill = rd_bkt.fill + gbrnp_pkg::FILL_W'(1);
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      clr_rsp_in = clr_rsp_ff;
      s1_vld_in = 1'b0;
      s2_vld_in = s1_vld_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in = rsp_id_ff;
      rsp_dist_in = rsp_dist_ff;
      row_in = gbrnp_pkg::div_cell(gbrnp_pkg::DIM_W'(y_ff[CW-1:4]));
      col_in = gbrnp_pkg::div_cell(gbrnp_pkg::DIM_W'(x_ff[CW-1:4]));
      rmax_in = gbrnp_pkg::div_cell(h_eff);
      cmax_in = gbrnp_pkg::div_cell(w_eff);
      outside_in = ({1'b0, x_ff} >= {w_eff, 4'b0000}) ||
                   ({1'b0, y_ff} >= {h_eff, 4'b0000});
      r_in = r_ff;
      c_in = c_ff;
      r1_in = r1_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      base_in = base_ff;
      ram_we = 1'b0;
      ram_addr = AW'(base_ff + AW'(c_ff));
      ram_wdata = wr_bkt;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_PREP2;
         end
         S_PREP2: begin
            r_in = GW'(r0_w);
            r1_in = GW'(r1_w);
            c0_in = GW'(c0_w);
            c1_in = GW'(c1_w);
            base_in = AW'(AW'(mrow) * AW'(gbrnp_pkg::GRID_N));
            case (req_ff)
               gbrnp_pkg::REQ_INSERT: begin
                  c_in = col_ff;
                  if (outside_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = gbrnp_pkg::ST_OUTSIDE;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end
               gbrnp_pkg::REQ_QUERY: begin
                  c_in = GW'(c0_w);
                  if (scan_empty) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = gbrnp_pkg::ST_NO_MATCH;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               gbrnp_pkg::REQ_CLEAR: begin
                  clr_addr_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in = S_CLR;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = gbrnp_pkg::ST_NO_MATCH;
                  state_in = S_IDLE;
               end
            endcase
            rsp_id_in = '0;
            rsp_dist_in = '0;
         end
         S_INS_RD: begin
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            rsp_valid_in = 1'b1;
            if (32'(rd_bkt.fill) >= NS) begin
               rsp_status_in = gbrnp_pkg::ST_FULL;
            end else begin
               ram_we = 1'b1;
               rsp_status_in = gbrnp_pkg::ST_STORED;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            s1_vld_in = 1'b1;
            if (c_ff == c1_ff) begin
               c_in = c0_ff;
               if (r_ff == r1_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  r_in = r_ff + GW'(1);
                  base_in = AW'(base_ff + AW'(gbrnp_pkg::GRID_N));
               end
            end else begin
               c_in = c_ff + GW'(1);
            end
         end
         S_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_status_in = gbrnp_pkg::ST_MATCH;
                  rsp_id_in = 16'(best_id_ff);
                  rsp_dist_in = 12'(best_ff);
               end else begin
                  rsp_status_in = gbrnp_pkg::ST_NO_MATCH;
               end
               state_in = S_IDLE;
            end
         end
         S_CLR: begin
            ram_we = 1'b1;
            ram_addr = clr_addr_ff;
            ram_wdata = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(gbrnp_pkg::NUM_BUCKETS - 1)) begin
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = gbrnp_pkg::ST_CLEARED;
                  rsp_id_in = '0;
                  rsp_dist_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_addr_ff <= '0;
         clr_rsp_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff <= gbrnp_pkg::CFG_W'(512);
         height_ff <= gbrnp_pkg::CFG_W'(512);
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         clr_rsp_ff <= clr_rsp_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               gbrnp_pkg::REG_WIDTH:  width_ff <= csr_wdata;
               gbrnp_pkg::REG_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_type;
         x_ff <= req_x_pos;
         y_ff <= req_y_pos;
         id_ff <= req_point_id;
      end
      if (state_ff == S_PREP) begin
         row_ff <= row_in;
         col_ff <= col_in;
         rmax_ff <= rmax_in;
         cmax_ff <= cmax_in;
         outside_ff <= outside_in;
      end
      r_ff <= r_in;
      c_ff <= c_in;
      r1_ff <= r1_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      base_ff <= base_in;
      for (int k = 0; k < NS; k++) begin
         dsq_ff[k] <= dsq_in[k];
         sid_ff[k] <= sid_in[k];
      end
      ok_ff <= ok_in;
      best_ff <= best_in;
      best_id_ff <= best_id_in;
      found_ff <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff <= rsp_id_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_match_id = rsp_id_ff;
   assign rsp_match_dist_sq = rsp_dist_ff;

   // The distance pipeline is empty whenever the block is idle.
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("distance pipeline active while idle");

   // One word gives one result: no two results back to back.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A match is always strictly inside the search radius.
   a_match_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == gbrnp_pkg::ST_MATCH) |->
      (32'(rsp_match_dist_sq) < gbrnp_pkg::LIMIT_SQ))
      else $error("match outside radius");

   // The bucket memory is written only by an insert or the clearing sweep.
   a_ram_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_INS_WR || state_ff == S_CLR))
      else $error("unexpected bucket memory write");

endmodule
